// ----- rtl/mxbd_pkg.sv -----
// package: word types and constants for the mxfp4 block dequantiser
package mxbd_pkg;

  localparam logic [31:0] CANON_NAN = 32'h7FC00000;
  localparam logic [31:0] INF_BITS  = 32'h7F800000;
  localparam logic [7:0]  NAN_SCALE = 8'hFF;

  typedef struct packed {
    logic [7:0] packed_byte;
    logic [7:0] scale_code;
    logic       last_item;
  } in_word_t;

  typedef struct packed {
    logic [31:0] first_value;
    logic [31:0] second_value;
    logic        last_out;
  } out_word_t;

endpackage

// ----- rtl/mxbd_lane.sv -----
// lane: decodes one e2m1 code with an e8m0 scale into float32 bits
module mxbd_lane (
  input  logic [3:0]  code,
  input  logic [7:0]  scale,
  output logic [31:0] value
);
  import mxbd_pkg::*;

  logic [1:0] k;
  logic       f;
  logic [9:0] biased;
  logic [2:0] sig;

  always_comb begin
    k      = code[2:1];
    f      = code[0] & (|code[2:1]);
    biased = {2'b00, scale} + {8'd0, k} - 10'd1;
    sig    = {2'b01, f};
    value  = '0;
    if (scale == NAN_SCALE) begin
      value = CANON_NAN;
    end else if (code[2:0] == 3'd0) begin
      value = {code[3], 31'd0};
    end else if (!biased[9] && biased[8:0] >= 9'd255) begin
      value = {code[3], 31'd0} | INF_BITS;
    end else if (!biased[9] && biased[8:0] >= 9'd1) begin
      value = {code[3], biased[7:0], f, 22'd0};
    end else if (!biased[9]) begin
      value = {code[3], 31'd0} | ({29'd0, sig} << 21);
    end else begin
      value = {code[3], 31'd0} | ({29'd0, sig} << 20);
    end
  end
endmodule

// ----- rtl/mxfp4_block_dequantizer.sv -----
// top level: two decode lanes merged into one registered result word
// result strobe: out_valid is registered and rises in the cycle after start is accepted
// throughput: one byte per cycle, busy is always low
// reset: synchronous active-low rst_n clears nibble order and the strobe
// the receiver cannot stall; each result is shown for one cycle only
module mxfp4_block_dequantizer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  mxbd_pkg::in_word_t  in_word,
  output logic                out_valid,
  output mxbd_pkg::out_word_t out_word,
  input  logic                cfg_we,
  input  logic                cfg_wdata
);
  import mxbd_pkg::*;

  logic        order_r;
  logic        valid_r;
  out_word_t   word_r;
  out_word_t   word_nxt;
  logic [31:0] lo_val;
  logic [31:0] hi_val;

  mxbd_lane u_lo (.code(in_word.packed_byte[3:0]), .scale(in_word.scale_code), .value(lo_val));
  mxbd_lane u_hi (.code(in_word.packed_byte[7:4]), .scale(in_word.scale_code), .value(hi_val));

  always_comb begin
    word_nxt.first_value  = order_r ? hi_val : lo_val;
    word_nxt.second_value = order_r ? lo_val : hi_val;
    word_nxt.last_out     = in_word.last_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        order_r <= cfg_wdata;
      end
      valid_r <= start;
    end
    if (start) begin
      word_r <= word_nxt;
    end
  end

  assign busy      = 1'b0;
  assign out_valid = valid_r;
  assign out_word  = word_r;

`ifndef SYNTHESIS
  a_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> out_valid) else $error("missing strobe");
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> out_word.last_out == $past(in_word.last_item)) else $error("last flag lost");
  a_nan: assert property (@(posedge clk) disable iff (!rst_n)
    (start && in_word.scale_code == NAN_SCALE) |=> out_word.first_value == CANON_NAN)
    else $error("nan scale not propagated");
`endif
endmodule

// ----- test/mxfp4_block_dequantizer_test.sv -----
// testbench: mxfp4 block dequantiser checked against its own float32 prediction
`timescale 1ns / 100ps

module mxfp4_block_dequantizer_test;
  import mxbd_pkg::*;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_word_t  in_word = '0;
  logic      out_valid;
  out_word_t out_word;
  logic      cfg_we = 1'b0;
  logic      cfg_wdata = 1'b0;

  out_word_t expected_words[$];
  logic      order_high_first = 1'b0;
  int        mismatches = 0;
  longint    cycles = 0;

  localparam longint CYCLE_LIMIT = 200000;

  mxfp4_block_dequantizer uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_word(in_word),
    .out_valid(out_valid), .out_word(out_word), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #4 clk = ~clk;

  function automatic logic [31:0] decode_e2m1(logic [3:0] code, logic [7:0] scale);
    logic [31:0] sign;
    logic [2:0]  mag;
    int          expo;
    logic        half;
    int          biased;
    sign = code[3] ? 32'h80000000 : 32'h0;
    mag = code[2:0];
    expo = mag >> 1;
    half = mag[0];
    if (mag < 3'd2) begin
      expo = 0;
      half = 1'b0;
    end
    if (scale == NAN_SCALE) return CANON_NAN;
    if (mag == 3'd0) return sign;
    biased = expo + scale - 1;
    if (biased >= 255) return sign | INF_BITS;
    if (biased >= 1) return sign | (32'(biased) << 23) | (32'(half) << 22);
    return sign | ((32'd2 + 32'(half)) << (biased + 21));
  endfunction

  function automatic out_word_t dequantize(in_word_t w);
    out_word_t r;
    logic [3:0] lo, hi;
    lo = w.packed_byte[3:0];
    hi = w.packed_byte[7:4];
    r.first_value = decode_e2m1(order_high_first ? hi : lo, w.scale_code);
    r.second_value = decode_e2m1(order_high_first ? lo : hi, w.scale_code);
    r.last_out = w.last_item;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("mxfp4_block_dequantizer_test NOT OK");
      $finish;
    end else if (rst_n && out_valid) begin
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected word", out_word.first_value, 32'h0);
      end else begin
        out_word_t e;
        e = expected_words.pop_front();
        if (out_word.first_value !== e.first_value)
          report_mismatch("first_value", out_word.first_value, e.first_value);
        if (out_word.second_value !== e.second_value)
          report_mismatch("second_value", out_word.second_value, e.second_value);
        if (out_word.last_out !== e.last_out)
          report_mismatch("last_out", 32'(out_word.last_out), 32'(e.last_out));
      end
    end
  end

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) n = 0;
    if (n != 0) start <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic send_word(logic [7:0] b, logic [7:0] s, logic l, bit gaps = 1'b1);
    in_word_t w;
    w.packed_byte = b;
    w.scale_code = s;
    w.last_item = l;
    if (gaps) idle_gap();
    start <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_words.push_back(dequantize(w));
    @(negedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (expected_words.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic set_order(logic v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    order_high_first = v;
  endtask

  task automatic test_extremes();
    logic [7:0] scales[8] = '{8'd0, 8'd1, 8'd2, 8'd127, 8'd252, 8'd253, 8'd254, 8'd255};
    for (int i = 0; i < 8; i++) send_word(8'hF7, scales[i], i == 7);
    send_word(8'h80, 8'd127, 1'b0);
    send_word(8'h08, 8'd0, 1'b0);
    send_word(8'h00, 8'd255, 1'b0);
    send_word(8'hFF, 8'd255, 1'b1);
  endtask

  task automatic test_all_codes();
    for (int c = 0; c < 16; c++) send_word({4'(c), 4'(15 - c)}, 8'd1, c == 15, 1'b0);
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) begin
      logic [7:0] s;
      case ($urandom_range(0, 4))
        0: s = 8'($urandom_range(0, 3));
        1: s = 8'($urandom_range(251, 255));
        default: s = 8'($urandom_range(0, 255));
      endcase
      send_word(8'($urandom_range(0, 255)), s, $urandom_range(0, 15) == 0);
    end
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_extremes();
    set_order(1'b1);
    test_all_codes();
    test_extremes();
    set_order(1'b0);
    test_all_codes();
    test_random(260);
    drain();
    set_order(1'b1);
    test_random(260);
    set_order(1'b0);
    test_random(20);
    drain();
    if (mismatches == 0) begin
      $display("mxfp4_block_dequantizer_test OK");
    end else begin
      $display("mxfp4_block_dequantizer_test NOT OK");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/mxbd_pkg.sv
rtl/mxbd_lane.sv
rtl/mxfp4_block_dequantizer.sv
test/mxfp4_block_dequantizer_test.sv
